### src/polyline_douglas_peucker_assert.svh
// ----------------------------------------------------------------------------
// polyline_douglas_peucker assertion macros
// Shorthand for clocked properties on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_DOUGLAS_PEUCKER_ASSERT_SVH
`define POLYLINE_DOUGLAS_PEUCKER_ASSERT_SVH

// same-cycle implication
`define PDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdp assertion failed");

// next-cycle implication
`define PDP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdp assertion failed");

`endif

### src/pdp_pkg.sv
// ----------------------------------------------------------------------------
// pdp_pkg
// Types and constants shared by the polyline simplifier.
// ----------------------------------------------------------------------------
package pdp_pkg;

    localparam int COORD_BITS = 20;
    localparam int WIDTH_BITS = 14;
    localparam logic [WIDTH_BITS-1:0] STROKE_RESET = 14'd160;

    localparam int DIG_W    = 4;
    localparam int MUL_RAW  = (2 * COORD_BITS + 4 > 2 * WIDTH_BITS + 2) ?
                              2 * COORD_BITS + 4 : 2 * WIDTH_BITS + 2;
    localparam int MUL_W    = ((MUL_RAW + DIG_W - 1) / DIG_W) * DIG_W;
    localparam int PROD_W   = 2 * MUL_W;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic                         last_point;
    } t_point;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] kept_x;
        logic signed [COORD_BITS-1:0] kept_y;
        logic                         final_kept;
        logic                         points_dropped;
    } t_result;

    typedef struct packed {
        logic                    start;
        logic signed [MUL_W-1:0] a;
        logic signed [MUL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_INIT,
        ST_POP,
        ST_SEG,
        ST_RDF,
        ST_RDL,
        ST_LEN_X,
        ST_LEN_Y,
        ST_PT_RD,
        ST_PT_LAT,
        ST_T_X,
        ST_T_Y,
        ST_CHOOSE,
        ST_C_A,
        ST_C_B,
        ST_C_SQ,
        ST_Q_X,
        ST_Q_Y,
        ST_Q_SC,
        ST_CMP,
        ST_W2,
        ST_THR,
        ST_PUSH2,
        ST_EMIT,
        ST_EMIT_OUT
    } t_state;

    function automatic logic signed [MUL_W-1:0] sx_d(input logic signed [COORD_BITS:0] v);
        return MUL_W'(v);
    endfunction

    function automatic logic signed [MUL_W-1:0] sx_p(input logic signed [PROD_W-1:0] v);
        return MUL_W'(v);
    endfunction

endpackage

### src/polyline_douglas_peucker.sv
// ----------------------------------------------------------------------------
// polyline_douglas_peucker
// Douglas-Peucker polyline simplifier with a shared iterative multiplier.
// ----------------------------------------------------------------------------
// Points enter on i_point, one beat per cycle while busy is low, when start is
// high. A point equal to the previous stored point is skipped; points past
// MAX_POINTS are dropped and flag points_dropped on that run's results.
// A beat with last_point high starts a run: busy rises and the kept points
// leave on o_result, each shown for one cycle with o_result_strobe, in index
// order; final_kept marks the last. busy falls the cycle after that beat.
// A run is paced by the shared multiplier: each multiply is an issue, 11
// radix-16 digit steps and a response. A run opens with a set-up step and
// one stack pop closes it. Per segment: a pop, a stack read, reads of both
// end points and 4 multiplies, plus a second push when it splits; a segment
// with no interior point is only popped and read. Per interior point: 2
// multiplies on a degenerate segment, else 5 multiplies. Emitting visits
// every stored point and outputs each kept point. Reset returns to the
// empty polyline and stroke width 160. The receiver cannot stall; results
// are never held back. The user writes stroke_width by i_cfg_we /
// i_cfg_wdata only while busy is low; the block does not enforce this.
// ----------------------------------------------------------------------------
module polyline_douglas_peucker #(
    parameter int MAX_POINTS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  pdp_pkg::t_point                  i_point,
    input  logic                             i_cfg_we,
    input  logic [pdp_pkg::WIDTH_BITS-1:0]   i_cfg_wdata,
    output pdp_pkg::t_result                 o_result,
    output logic                             o_result_strobe
);
    import pdp_pkg::*;

    logic [WIDTH_BITS-1:0] r_stroke_width;
    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stroke_width <= STROKE_RESET;
        end else if (i_cfg_we) begin
            r_stroke_width <= i_cfg_wdata;
        end
    end

    pdp_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_point        (i_point),
        .i_stroke_width (r_stroke_width),
        .o_busy         (busy),
        .o_result       (o_result),
        .o_result_strobe(o_result_strobe),
        .o_mul_req      (mul_req),
        .i_mul_rsp      (mul_rsp)
    );

    pdp_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_rsp  (mul_rsp)
    );

endmodule

### src/pdp_mul.sv
// ----------------------------------------------------------------------------
// pdp_mul
// Shared signed multiplier, one radix-16 digit per cycle on magnitudes.
// ----------------------------------------------------------------------------
module pdp_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdp_pkg::t_mul_req  i_req,
    output pdp_pkg::t_mul_rsp  o_rsp
);
    import pdp_pkg::*;

    localparam int ND   = MUL_W / DIG_W;
    localparam int CNTW = $clog2(ND + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNTW-1:0]   r_cnt;
    logic [PROD_W-1:0] r_ma;
    logic [MUL_W-1:0]  r_mb;
    logic [PROD_W-1:0] r_acc;
    logic              r_neg;
    logic [MUL_W-1:0]  mag_a;
    logic [MUL_W-1:0]  mag_b;
    logic [PROD_W-1:0] pp;

    assign mag_a = i_req.a[MUL_W-1] ? (~i_req.a + MUL_W'(1)) : i_req.a;
    assign mag_b = i_req.b[MUL_W-1] ? (~i_req.b + MUL_W'(1)) : i_req.b;
    assign pp    = r_ma * PROD_W'(r_mb[DIG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(ND);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= PROD_W'(mag_a);
            r_mb  <= mag_b;
            r_acc <= '0;
            r_neg <= i_req.a[MUL_W-1] ^ i_req.b[MUL_W-1];
        end else if (r_busy) begin
            r_acc <= r_acc + pp;
            r_ma  <= r_ma << DIG_W;
            r_mb  <= r_mb >> DIG_W;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_neg ? (~r_acc + PROD_W'(1)) : r_acc;

endmodule

### src/pdp_ctrl.sv
// ----------------------------------------------------------------------------
// pdp_ctrl
// Point store, segment stack and the sequencer that drives the multiplier.
// ----------------------------------------------------------------------------
module pdp_ctrl #(
    parameter int MAX_POINTS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  pdp_pkg::t_point                  i_point,
    input  logic [pdp_pkg::WIDTH_BITS-1:0]   i_stroke_width,
    output logic                             o_busy,
    output pdp_pkg::t_result                 o_result,
    output logic                             o_result_strobe,
    output pdp_pkg::t_mul_req                o_mul_req,
    input  pdp_pkg::t_mul_rsp                i_mul_rsp
);
    import pdp_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = 2 * IW;
    localparam int DW = COORD_BITS + 1;

    logic [2*COORD_BITS-1:0] mem_pt  [MAX_POINTS];
    logic [SW-1:0]           mem_stk [MAX_POINTS];

    t_state r_state, n_state;

    logic [2*COORD_BITS-1:0] r_pt_rd;
    logic [SW-1:0]           r_stk_rd;
    logic [IW-1:0]           pt_raddr, pt_waddr, stk_raddr, stk_waddr;
    logic                    pt_we, stk_we;
    logic [2*COORD_BITS-1:0] pt_wdata;
    logic [SW-1:0]           stk_wdata;

    logic [CW-1:0]           r_cnt, r_top, r_i;
    logic [MAX_POINTS-1:0]   r_keep;
    logic                    r_ovf, r_wait, r_scale;
    logic [IW-1:0]           r_f, r_l, r_besti;
    logic signed [COORD_BITS-1:0] r_lx, r_ly, r_ax, r_ay, r_bx, r_by;
    logic signed [DW-1:0]    r_dx, r_dy, r_vx, r_vy, r_wx, r_wy, r_ux, r_uy;
    logic signed [PROD_W-1:0] r_acc, r_t, r_len2, r_score, r_best;
    t_result                 r_out;
    logic                    r_out_v;

    logic signed [COORD_BITS-1:0] rd_x, rd_y;
    logic [IW-1:0]           seg_f, seg_l;
    logic                    accept, is_new, can_store, mul_st, done;
    logic [CW-1:0]           top_m1, cnt_m1, i_p1;
    logic signed [PROD_W+1:0] best4, thr;
    logic                    gt;
    logic                    len2_zero;

    assign rd_x      = r_pt_rd[2*COORD_BITS-1:COORD_BITS];
    assign rd_y      = r_pt_rd[COORD_BITS-1:0];
    assign seg_f     = r_stk_rd[SW-1:IW];
    assign seg_l     = r_stk_rd[IW-1:0];
    assign accept    = i_start && (r_state == ST_IDLE);
    assign is_new    = (r_cnt == '0) || (i_point.point_x != r_lx) || (i_point.point_y != r_ly);
    assign can_store = r_cnt < CW'(MAX_POINTS);
    assign top_m1    = r_top - CW'(1);
    assign cnt_m1    = r_cnt - CW'(1);
    assign i_p1      = r_i + CW'(1);
    assign done      = i_mul_rsp.done;
    assign best4     = $signed({r_best, 2'b00});
    assign thr       = (PROD_W+2)'(i_mul_rsp.prod);
    assign gt        = best4 > thr;
    assign len2_zero = (r_len2 == '0);

    always_comb begin
        unique case (r_state)
            ST_LEN_X, ST_LEN_Y, ST_T_X, ST_T_Y, ST_C_A, ST_C_B, ST_C_SQ,
            ST_Q_X, ST_Q_Y, ST_Q_SC, ST_W2, ST_THR: mul_st = 1'b1;
            default:                                  mul_st = 1'b0;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            mem_pt[pt_waddr] <= pt_wdata;
        end
        r_pt_rd <= mem_pt[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            mem_stk[stk_waddr] <= stk_wdata;
        end
        r_stk_rd <= mem_stk[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_point.last_point && ((r_cnt != '0) || is_new)) begin
                    n_state = ST_INIT;
                end
            end
            ST_INIT:  n_state = ST_POP;
            ST_POP:   n_state = (r_top == '0) ? ST_EMIT : ST_SEG;
            ST_SEG: begin
                if ((CW'(seg_l) <= CW'(seg_f) + CW'(1)) || (CW'(seg_l) >= r_cnt)) begin
                    n_state = ST_POP;
                end else begin
                    n_state = ST_RDF;
                end
            end
            ST_RDF:    n_state = ST_RDL;
            ST_RDL:    n_state = ST_LEN_X;
            ST_LEN_X:  if (done) n_state = ST_LEN_Y;
            ST_LEN_Y:  if (done) n_state = ST_PT_RD;
            ST_PT_RD:  n_state = ST_PT_LAT;
            ST_PT_LAT: n_state = len2_zero ? ST_Q_X : ST_T_X;
            ST_T_X:    if (done) n_state = ST_T_Y;
            ST_T_Y:    if (done) n_state = ST_CHOOSE;
            ST_CHOOSE: begin
                if (r_t[PROD_W-1] || (r_t == '0) || (r_t >= r_len2)) begin
                    n_state = ST_Q_X;
                end else begin
                    n_state = ST_C_A;
                end
            end
            ST_C_A:    if (done) n_state = ST_C_B;
            ST_C_B:    if (done) n_state = ST_C_SQ;
            ST_C_SQ:   if (done) n_state = ST_CMP;
            ST_Q_X:    if (done) n_state = ST_Q_Y;
            ST_Q_Y:    if (done) n_state = r_scale ? ST_Q_SC : ST_CMP;
            ST_Q_SC:   if (done) n_state = ST_CMP;
            ST_CMP:    n_state = (i_p1 == CW'(r_l)) ? ST_W2 : ST_PT_RD;
            ST_W2:     if (done) n_state = ST_THR;
            ST_THR:    if (done) n_state = gt ? ST_PUSH2 : ST_POP;
            ST_PUSH2:  n_state = ST_POP;
            ST_EMIT: begin
                if (r_i == r_cnt) begin
                    n_state = ST_IDLE;
                end else if (r_keep[r_i[IW-1:0]]) begin
                    n_state = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT: n_state = ST_EMIT;
            default:     n_state = ST_IDLE;
        endcase
    end

    // memory ports and multiplier requests
    always_comb begin
        pt_we     = 1'b0;
        pt_waddr  = r_cnt[IW-1:0];
        pt_wdata  = {i_point.point_x, i_point.point_y};
        pt_raddr  = r_i[IW-1:0];
        stk_we    = 1'b0;
        stk_waddr = r_top[IW-1:0];
        stk_wdata = {r_besti, r_l};
        stk_raddr = top_m1[IW-1:0];
        o_mul_req.start = mul_st && !r_wait;
        o_mul_req.a     = '0;
        o_mul_req.b     = '0;
        unique case (r_state)
            ST_IDLE:   pt_we = accept && is_new && can_store;
            ST_INIT: begin
                stk_we    = 1'b1;
                stk_wdata = {IW'(0), cnt_m1[IW-1:0]};
            end
            ST_SEG:    pt_raddr = seg_f;
            ST_RDF:    pt_raddr = r_l;
            ST_LEN_X:  begin o_mul_req.a = sx_d(r_dx); o_mul_req.b = sx_d(r_dx); end
            ST_LEN_Y:  begin o_mul_req.a = sx_d(r_dy); o_mul_req.b = sx_d(r_dy); end
            ST_T_X:    begin o_mul_req.a = sx_d(r_vx); o_mul_req.b = sx_d(r_dx); end
            ST_T_Y:    begin o_mul_req.a = sx_d(r_vy); o_mul_req.b = sx_d(r_dy); end
            ST_C_A:    begin o_mul_req.a = sx_d(r_vx); o_mul_req.b = sx_d(r_dy); end
            ST_C_B:    begin o_mul_req.a = sx_d(r_vy); o_mul_req.b = sx_d(r_dx); end
            ST_C_SQ:   begin o_mul_req.a = sx_p(r_acc); o_mul_req.b = sx_p(r_acc); end
            ST_Q_X:    begin o_mul_req.a = sx_d(r_ux); o_mul_req.b = sx_d(r_ux); end
            ST_Q_Y:    begin o_mul_req.a = sx_d(r_uy); o_mul_req.b = sx_d(r_uy); end
            ST_Q_SC:   begin o_mul_req.a = sx_p(r_acc); o_mul_req.b = sx_p(r_len2); end
            ST_W2: begin
                o_mul_req.a = MUL_W'(i_stroke_width);
                o_mul_req.b = MUL_W'(i_stroke_width);
            end
            ST_THR: begin
                o_mul_req.a = sx_p(r_acc);
                o_mul_req.b = len2_zero ? MUL_W'(1) : sx_p(r_len2);
                stk_we      = done && gt && (r_top < CW'(MAX_POINTS));
            end
            ST_PUSH2: begin
                stk_we    = r_top < CW'(MAX_POINTS);
                stk_wdata = {r_f, r_besti};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_top   <= '0;
            r_keep  <= '0;
            r_ovf   <= 1'b0;
            r_wait  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (o_mul_req.start) begin
                r_wait <= 1'b1;
            end else if (done) begin
                r_wait <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && is_new) begin
                        if (can_store) begin
                            r_cnt <= r_cnt + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                ST_INIT: begin
                    r_keep[0]               <= 1'b1;
                    r_keep[cnt_m1[IW-1:0]]  <= 1'b1;
                    r_top                   <= CW'(1);
                end
                ST_POP: begin
                    if (r_top != '0) begin
                        r_top <= top_m1;
                    end
                end
                ST_THR: begin
                    if (done && gt) begin
                        r_keep[r_besti] <= 1'b1;
                        if (r_top < CW'(MAX_POINTS)) begin
                            r_top <= r_top + CW'(1);
                        end
                    end
                end
                ST_PUSH2: begin
                    if (r_top < CW'(MAX_POINTS)) begin
                        r_top <= r_top + CW'(1);
                    end
                end
                ST_EMIT: begin
                    if (r_i == r_cnt) begin
                        r_cnt  <= '0;
                        r_keep <= '0;
                        r_ovf  <= 1'b0;
                    end
                end
                ST_EMIT_OUT: r_out_v <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept && is_new && can_store) begin
                    r_lx <= i_point.point_x;
                    r_ly <= i_point.point_y;
                end
            end
            ST_POP: r_i <= '0;
            ST_SEG: begin
                r_f <= seg_f;
                r_l <= seg_l;
            end
            ST_RDF: begin
                r_ax <= rd_x;
                r_ay <= rd_y;
            end
            ST_RDL: begin
                r_bx <= rd_x;
                r_by <= rd_y;
                r_dx <= DW'(rd_x) - DW'(r_ax);
                r_dy <= DW'(rd_y) - DW'(r_ay);
            end
            ST_LEN_X: if (done) r_acc <= i_mul_rsp.prod;
            ST_LEN_Y: begin
                if (done) begin
                    r_len2  <= r_acc + i_mul_rsp.prod;
                    r_i     <= CW'(r_f) + CW'(1);
                    r_best  <= '0;
                    r_besti <= r_f;
                end
            end
            ST_PT_LAT: begin
                r_vx    <= DW'(rd_x) - DW'(r_ax);
                r_vy    <= DW'(rd_y) - DW'(r_ay);
                r_wx    <= DW'(rd_x) - DW'(r_bx);
                r_wy    <= DW'(rd_y) - DW'(r_by);
                r_ux    <= DW'(rd_x) - DW'(r_ax);
                r_uy    <= DW'(rd_y) - DW'(r_ay);
                r_scale <= 1'b0;
            end
            ST_T_X: if (done) r_acc <= i_mul_rsp.prod;
            ST_T_Y: if (done) r_t <= r_acc + i_mul_rsp.prod;
            ST_CHOOSE: begin
                r_scale <= 1'b1;
                if (!(r_t[PROD_W-1] || (r_t == '0)) && (r_t >= r_len2)) begin
                    r_ux <= r_wx;
                    r_uy <= r_wy;
                end
            end
            ST_C_A:  if (done) r_acc <= i_mul_rsp.prod;
            ST_C_B:  if (done) r_acc <= r_acc - i_mul_rsp.prod;
            ST_C_SQ: if (done) r_score <= i_mul_rsp.prod;
            ST_Q_X:  if (done) r_acc <= i_mul_rsp.prod;
            ST_Q_Y: begin
                if (done) begin
                    r_acc   <= r_acc + i_mul_rsp.prod;
                    r_score <= r_acc + i_mul_rsp.prod;
                end
            end
            ST_Q_SC: if (done) r_score <= i_mul_rsp.prod;
            ST_CMP: begin
                if (r_score > r_best) begin
                    r_best  <= r_score;
                    r_besti <= r_i[IW-1:0];
                end
                r_i <= i_p1;
            end
            ST_W2: if (done) r_acc <= i_mul_rsp.prod;
            ST_EMIT: begin
                if ((r_i != r_cnt) && !r_keep[r_i[IW-1:0]]) begin
                    r_i <= i_p1;
                end
            end
            ST_EMIT_OUT: begin
                r_out.kept_x         <= rd_x;
                r_out.kept_y         <= rd_y;
                r_out.final_kept     <= (r_i == cnt_m1);
                r_out.points_dropped <= r_ovf;
                r_i                  <= i_p1;
            end
            default: ;
        endcase
    end

    assign o_busy          = (r_state != ST_IDLE);
    assign o_result        = r_out;
    assign o_result_strobe = r_out_v;

endmodule

### src/pdp_checker.sv
// ----------------------------------------------------------------------------
// pdp_checker
// Port-level checks on the run sequencing of the simplifier.
// ----------------------------------------------------------------------------
`include "polyline_douglas_peucker_assert.svh"

module pdp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input pdp_pkg::t_result  o_result,
    input logic              o_result_strobe
);
    import pdp_pkg::*;

    // a run only begins on an accepted beat
    `PDP_ASSERT_IMP(a_busy_rise, $rose(busy), $past(start))
    `PDP_ASSERT_IMP(a_strobe_busy, o_result_strobe, busy)
    `PDP_ASSERT_NXT(a_final_idle, o_result_strobe && o_result.final_kept, !busy)
    `PDP_ASSERT_IMP(a_busy_fall, $fell(busy), $past(o_result_strobe && o_result.final_kept))

endmodule

bind polyline_douglas_peucker pdp_checker u_pdp_checker (.*);
